>>> hw/rtl/vnmd_pkg.sv
// Shared types and constants for the volume nonzero-mean decimator.
package vnmd_pkg;

    localparam int VOXEL_W           = 8;
    localparam int HALF_SIDE_W       = 8;
    localparam int SUM_W             = 11;
    localparam int CNT_W             = 4;
    localparam int DIV_W             = 12;
    localparam int MAX_HALF_SIDE_DEF = 128;

    localparam logic [HALF_SIDE_W-1:0] HALF_SIDE_RESET = 8'd128;
    localparam logic [SUM_W-1:0]       SUM_MAX         = 11'd2047;
    localparam logic [CNT_W-1:0]       CNT_MAX         = 4'd15;
    localparam logic [VOXEL_W-1:0]     MEAN_MAX        = 8'd255;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_OUT
    } state_t;

endpackage

>>> hw/rtl/vnmd_div.sv
// Restoring divider, one quotient bit per cycle, for the group mean.
module vnmd_div
    import vnmd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [DIV_W-1:0]  quo_reg;

    logic [CNT_W:0]    trial;
    logic              fits;

    // Shift the next dividend bit into the partial remainder and test it
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Control: count the steps and flag the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: restore or subtract, shift the quotient bit in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, div_reg}) : CNT_W'(trial);
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/volume_nonzero_mean_decimator_top.sv
// Top level of the volume nonzero-mean decimator: plane store, sequencer, output register.
//
// Voxels of a cube with side 2*half_side enter on the input channel
// (in_valid/in_ready, fields voxel and start_req) in raster order, x fastest.
// Each 2x2x2 group yields one beat on the output channel (out_valid/out_ready,
// fields value and last): the rounded mean of the group's nonzero voxels, or 0.
// start_req on a beat restarts the position counters at (0,0,0); after the
// final voxel of a volume the counters wrap, so volumes may follow directly.
// half_side is written through cfg_we/cfg_data; the user must write it only
// while the block is idle, which the block does not enforce. A voxel that
// does not close a group is accepted, then read-modify-written in the plane
// store, a single-port synchronous memory with a registered read. A voxel
// closing a group with nonzero members then runs the bit-serial 12-step
// divider; an all-zero group skips it. The result sits in an output register;
// the next voxel is accepted while it waits, and the sequencer holds only when
// a second result is ready before the receiver took the first. Reset clears the
// counters, the sequencer and the output valid, and sets half_side to 128; the
// plane store is not cleared, since a group's first voxel overwrites its entry.
module volume_nonzero_mean_decimator_top
    import vnmd_pkg::*;
#(
    parameter int MAX_HALF_SIDE = MAX_HALF_SIDE_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [HALF_SIDE_W-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VOXEL_W-1:0]     voxel,
    input  logic                   start_req,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VOXEL_W-1:0]     value,
    output logic                   last
);

    localparam int CW    = $clog2(2 * MAX_HALF_SIDE);
    localparam int SW    = CW + 1;
    localparam int DEPTH = MAX_HALF_SIDE * MAX_HALF_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = SUM_W + CNT_W;

    state_t state_reg, state_next;

    logic [HALF_SIDE_W-1:0] half_side_reg;
    logic [CW-1:0]          pos_x_reg, pos_y_reg, pos_z_reg;
    logic [CW-1:0]          pos_x_next, pos_y_next, pos_z_next;

    logic [VOXEL_W-1:0]     voxel_reg;
    logic                   first_reg;
    logic                   glast_reg;
    logic                   vlast_reg;
    logic [AW-1:0]          idx_reg;
    logic [VOXEL_W-1:0]     mean_reg;

    logic                   out_valid_reg;
    logic [VOXEL_W-1:0]     value_reg;
    logic                   last_reg;

    logic [MW-1:0]          mem [DEPTH];
    logic [MW-1:0]          rd_data_reg;

    logic [SW-1:0]          h_eff, side, side_m1;
    logic [CW-1:0]          px_s, py_s, pz_s, px, py, pz;
    logic [SW-1:0]          nx, ny, nz;
    logic                   first_c, glast_c, vlast_c;
    logic [AW-1:0]          idx_c;

    logic [SUM_W-1:0]       base_sum, sum_new;
    logic [CNT_W-1:0]       base_cnt, cnt_new;
    logic [SUM_W:0]         sum_add;
    logic [DIV_W-1:0]       dividend;

    logic                   accept;
    logic                   mem_we;
    logic                   div_start;
    logic                   out_load;
    logic                   out_free;
    logic                   div_done;
    logic [DIV_W-1:0]       quotient;
    logic [VOXEL_W-1:0]     quo_sat;

    // Effective side: zero acts as one, clamp to the store size
    always_comb
    begin
        if (half_side_reg == '0)
            h_eff = SW'(1);
        else if (32'(half_side_reg) > 32'(MAX_HALF_SIDE))
            h_eff = SW'(MAX_HALF_SIDE);
        else
            h_eff = SW'(half_side_reg);
        side    = h_eff << 1;
        side_m1 = side - SW'(1);
    end

    // Position of the incoming voxel: restart, then drop out-of-range counters
    always_comb
    begin
        px_s = start_req ? '0 : pos_x_reg;
        py_s = start_req ? '0 : pos_y_reg;
        pz_s = start_req ? '0 : pos_z_reg;
        px   = ({1'b0, px_s} >= side) ? '0 : px_s;
        py   = ({1'b0, py_s} >= side) ? '0 : py_s;
        pz   = ({1'b0, pz_s} >= side) ? '0 : pz_s;

        first_c = ~px[0] & ~py[0] & ~pz[0];
        glast_c =  px[0] &  py[0] &  pz[0];
        vlast_c = ({1'b0, px} == side_m1) && ({1'b0, py} == side_m1)
                  && ({1'b0, pz} == side_m1);
        idx_c   = AW'(32'(py >> 1) * 32'(MAX_HALF_SIDE) + 32'(px >> 1));
    end

    // Advance the raster counters with wrap
    always_comb
    begin
        nx = {1'b0, px} + SW'(1);
        ny = {1'b0, py} + SW'(1);
        nz = {1'b0, pz} + SW'(1);
        pos_x_next = px;
        pos_y_next = py;
        pos_z_next = pz;
        if (nx >= side)
        begin
            pos_x_next = '0;
            if (ny >= side)
            begin
                pos_y_next = '0;
                pos_z_next = (nz >= side) ? '0 : nz[CW-1:0];
            end
            else
            begin
                pos_y_next = ny[CW-1:0];
            end
        end
        else
        begin
            pos_x_next = nx[CW-1:0];
        end
    end

    // Accumulate into the fetched entry; the group's first voxel starts fresh
    always_comb
    begin
        base_sum = first_reg ? '0 : rd_data_reg[MW-1:CNT_W];
        base_cnt = first_reg ? '0 : rd_data_reg[CNT_W-1:0];
        sum_add  = {1'b0, base_sum} + (SUM_W+1)'(voxel_reg);
        if (voxel_reg != '0)
        begin
            sum_new = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
            cnt_new = (base_cnt == CNT_MAX) ? CNT_MAX : base_cnt + CNT_W'(1);
        end
        else
        begin
            sum_new = base_sum;
            cnt_new = base_cnt;
        end
        dividend = DIV_W'(sum_new) + DIV_W'(cnt_new >> 1);
        quo_sat  = (quotient > DIV_W'(MEAN_MAX)) ? MEAN_MAX : quotient[VOXEL_W-1:0];
    end

    assign out_free = ~out_valid_reg | out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_READ;
            S_READ:
                if (glast_reg)
                    state_next = (cnt_new == '0) ? S_OUT : S_DIV;
                else
                    state_next = S_IDLE;
            S_DIV:
                if (div_done)
                    state_next = S_OUT;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
                in_ready = 1'b1;
            S_READ:
            begin
                mem_we    = 1'b1;
                div_start = glast_reg && (cnt_new != '0);
            end
            S_DIV:
                ;
            S_OUT:
                out_load = out_free;
            default:
                ;
        endcase
    end

    assign accept = in_valid & in_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            half_side_reg <= HALF_SIDE_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                half_side_reg <= cfg_data;
            if (accept)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
                pos_z_reg <= pos_z_next;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the accepted voxel and its group position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            voxel_reg <= voxel;
            first_reg <= first_c;
            glast_reg <= glast_c;
            vlast_reg <= vlast_c;
            idx_reg   <= idx_c;
        end
        if (state_reg == S_READ && glast_reg && cnt_new == '0)
            mean_reg <= '0;
        else if (state_reg == S_DIV && div_done)
            mean_reg <= quo_sat;
        if (out_load)
        begin
            value_reg <= mean_reg;
            last_reg  <= vlast_reg;
        end
    end

    // Plane store: read on accept, write back in the following cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx_reg] <= {sum_new, cnt_new};
        if (accept)
            rd_data_reg <= mem[idx_c];
    end

    vnmd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (cnt_new),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign last      = last_reg;

endmodule

>>> verif/tb_volume_nonzero_mean_decimator_top.sv
// Testbench for the volume nonzero-mean decimator: voxel streams checked against a group-mean tracker.
`timescale 1ns / 100ps

module tb_volume_nonzero_mean_decimator_top;
    import vnmd_pkg::*;

    localparam int PLANE_SIDE    = MAX_HALF_SIDE_DEF;
    localparam int PLANE_DEPTH   = PLANE_SIDE * PLANE_SIDE;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_VOXELS = 800;

    typedef struct packed {
        logic [VOXEL_W-1:0] value;
        logic               last;
    } group_mean_t;

    // Tracks the plane store and position counters, and queues the group means due out
    class group_mean_tracker;
        bit [SUM_W-1:0]       plane_sum  [PLANE_DEPTH];
        bit [CNT_W-1:0]       plane_cnt  [PLANE_DEPTH];
        bit                   plane_seen [PLANE_DEPTH];
        bit [HALF_SIDE_W-1:0] half_side;
        int unsigned          pos_x;
        int unsigned          pos_y;
        int unsigned          pos_z;
        group_mean_t          due_means [$];
        int unsigned          mismatches;

        function new();
            half_side  = HALF_SIDE_RESET;
            pos_x      = 0;
            pos_y      = 0;
            pos_z      = 0;
            mismatches = 0;
        endfunction

        // Input cube side, with half_side 0 taken as 1 and large values capped
        function int unsigned side();
            int unsigned h;
            h = half_side;
            if (h == 0)
                h = 1;
            if (h > PLANE_SIDE)
                h = PLANE_SIDE;
            return 2 * h;
        endfunction

        // Position the next voxel lands on: restart on request, drop counters past the side
        function void clipped(input bit restart, output int unsigned x, y, z);
            int unsigned s;
            s = side();
            if (restart)
            begin
                x = 0;
                y = 0;
                z = 0;
            end
            else
            begin
                x = pos_x;
                y = pos_y;
                z = pos_z;
            end
            if (x >= s)
                x = 0;
            if (y >= s)
                y = 0;
            if (z >= s)
                z = 0;
        endfunction

        // True when a plain voxel would read a store entry that nothing has written yet
        function bit needs_restart();
            int unsigned x, y, z;
            clipped(1'b0, x, y, z);
            return !(x % 2 == 0 && y % 2 == 0 && z % 2 == 0)
                   && !plane_seen[(y / 2) * PLANE_SIDE + x / 2];
        endfunction

        // Fold one accepted voxel into the store; queue a mean when it closes a group
        function void take_voxel(input bit [VOXEL_W-1:0] v, input bit restart);
            int unsigned x, y, z, s, slot, acc, n, mean;
            group_mean_t due;
            s = side();
            clipped(restart, x, y, z);
            slot = (y / 2) * PLANE_SIDE + x / 2;

            // First member of a group overwrites the entry
            if (x % 2 == 0 && y % 2 == 0 && z % 2 == 0)
            begin
                acc = 0;
                n   = 0;
            end
            else
            begin
                acc = plane_sum[slot];
                n   = plane_cnt[slot];
            end
            if (v != 0)
            begin
                acc = acc + v;
                n   = n + 1;
                if (acc > SUM_MAX)
                    acc = SUM_MAX;
                if (n > CNT_MAX)
                    n = CNT_MAX;
            end
            plane_sum[slot]  = SUM_W'(acc);
            plane_cnt[slot]  = CNT_W'(n);
            plane_seen[slot] = 1'b1;

            // Last member of a group emits the rounded mean
            if (x % 2 == 1 && y % 2 == 1 && z % 2 == 1)
            begin
                mean = 0;
                if (n != 0)
                    mean = (acc + n / 2) / n;
                if (mean > MEAN_MAX)
                    mean = MEAN_MAX;
                due.value = VOXEL_W'(mean);
                due.last  = (x == s - 1 && y == s - 1 && z == s - 1);
                due_means.push_back(due);
            end

            // Advance in raster order, wrapping at the end of the volume
            x = x + 1;
            if (x >= s)
            begin
                x = 0;
                y = y + 1;
                if (y >= s)
                begin
                    y = 0;
                    z = z + 1;
                    if (z >= s)
                        z = 0;
                end
            end
            pos_x = x;
            pos_y = y;
            pos_z = z;
        endfunction

        // Compare one result beat against the oldest queued mean
        function void compare_mean(input logic [VOXEL_W-1:0] got_value, input logic got_last);
            group_mean_t due;
            if (due_means.size() == 0)
            begin
                $error("result beat with nothing due: value %0d last %0b", got_value, got_last);
                mismatches++;
                return;
            end
            due = due_means.pop_front();
            if (got_value !== due.value)
            begin
                $error("value: expected %0d, actual %0d", due.value, got_value);
                mismatches++;
            end
            if (got_last !== due.last)
            begin
                $error("last: expected %0b, actual %0b", due.last, got_last);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [HALF_SIDE_W-1:0] cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [VOXEL_W-1:0]     voxel     = '0;
    logic                   start_req = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [VOXEL_W-1:0]     value;
    logic                   last;

    group_mean_tracker tracker;
    int unsigned       burst_left   = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       ready_cycle  = 0;

    volume_nonzero_mean_decimator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .voxel     (voxel),
        .start_req (start_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .last      (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the result channel: free-running, random, periodic and sparse stretches
    always @(posedge clk)
    begin
        ready_cycle <= ready_cycle + 1;
        case ((ready_cycle / 300) % 4)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= (ready_cycle % 7 < 3);
            default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.compare_mean(value, last);
    end

    // Abort when neither channel has moved a beat for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 < STALL_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("volume_nonzero_mean_decimator_top verification failed");
            $finish;
        end
    end

    // Voxel mix: plenty of empties, some full-scale, some small, the rest spread over the range
    function automatic logic [VOXEL_W-1:0] rand_voxel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return '0;
        if (pick == 4)
            return '1;
        if (pick == 5)
            return VOXEL_W'($urandom_range(1, 3));
        return VOXEL_W'($urandom_range(0, 255));
    endfunction

    // Send one voxel beat, inserting a random gap between bursts; restart where needed
    task automatic send_voxel(input logic [VOXEL_W-1:0] v, input logic restart);
        int unsigned gap;
        logic        begin_flag;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left != 0)
            burst_left--;
        begin_flag = restart || tracker.needs_restart();
        in_valid  <= 1'b1;
        voxel     <= v;
        start_req <= begin_flag;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_voxel(v, begin_flag);
    endtask

    // Drop valid, wait for every due mean, then let the sequencer finish its last voxel
    task automatic settle_block();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (tracker.due_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_half(input logic [HALF_SIDE_W-1:0] h);
        cfg_we   <= 1'b1;
        cfg_data <= h;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tracker.half_side = h;
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned pick;
        int unsigned eff;
        int unsigned span;
        bit          fresh;
        logic [HALF_SIDE_W-1:0] h;

        tracker = new();
        sent    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill group 0 with full-scale voxels, mixed values elsewhere, and stop mid-volume
        write_half(8'd2);
        for (int i = 0; i < 22; i++)
        begin
            if (i % 4 < 2 && (i / 4) % 4 < 2)
                send_voxel(8'hFF, i == 0);
            else
                send_voxel((i % 3 == 0) ? 8'h00 : VOXEL_W'(i * 41), 1'b0);
        end

        // Shrink to half_side 0 (taken as 1, side 2): clipped x lands on the stale group and saturates its sum
        settle_block();
        write_half(8'd0);
        send_voxel(8'hFF, 1'b0);
        send_voxel(8'h00, 1'b0);

        // Random phases: mostly small cubes, whole volumes or partial runs, occasionally huge sides
        while (sent < RANDOM_VOXELS)
        begin
            settle_block();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                h = 8'd255;
            else if (pick == 1)
                h = 8'd128;
            else if (pick == 2)
                h = HALF_SIDE_W'($urandom_range(6, 12));
            else
                h = HALF_SIDE_W'($urandom_range(0, 5));
            write_half(h);
            eff = (h == 0) ? 1 : (h > PLANE_SIDE) ? PLANE_SIDE : h;
            if (eff <= 3 && $urandom_range(0, 1) == 1)
                span = 8 * eff * eff * eff * $urandom_range(1, 2);
            else
                span = $urandom_range(1, 150);
            fresh = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < span; i++)
                send_voxel(rand_voxel(), (i == 0 && fresh) || $urandom_range(0, 99) == 0);
            sent += span;
        end
        settle_block();

        if (tracker.mismatches == 0)
            $display("volume_nonzero_mean_decimator_top verification clean");
        else
            $display("volume_nonzero_mean_decimator_top verification failed");
        $finish;
    end

endmodule
